>>> rtl/cmfta_pkg.sv
// Shared widths, register indexes, payload types and level size function for the cube map unit.
package cmfta_pkg;

  localparam int SIZE_W  = 13;
  localparam int TEXEL_W = 12;
  localparam int FACE_W  = 3;
  localparam int IMG_W   = 7;
  localparam int LVL_W   = 4;

  localparam logic [LVL_W-1:0]  MAX_LEVEL  = 4'd12;
  localparam logic [SIZE_W-1:0] SIZE_LIMIT = 13'd4096;
  localparam logic [SIZE_W-1:0] BASE_RESET = 13'd256;

  // Configuration register indexes
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_BASE_WIDTH  = 1'b0;
  localparam cfg_index_t CFG_BASE_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Per-transaction data that rides alongside the divider
  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [IMG_W-1:0]  image_index;
    logic              zero;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } side_t;

  // Face size at a level: base clamped to 1..4096, halved per level, at least 1
  function automatic logic [SIZE_W-1:0] level_size(input logic [SIZE_W-1:0] base,
                                                   input logic [LVL_W-1:0]  lvl);
    logic [SIZE_W-1:0] b;
    b = base;
    if (b == '0) begin
      b = SIZE_W'(1);
    end
    if (b > SIZE_LIMIT) begin
      b = SIZE_LIMIT;
    end
    b = b >> lvl;
    if (b == '0) begin
      b = SIZE_W'(1);
    end
    return b;
  endfunction

endpackage

>>> rtl/cube_map_face_texel_address.sv
// Cube map face selection and texel address pipeline with restoring divider stages.
//
// Takes one lookup transaction per clock and never stalls: busy is always low.
// Each transaction's result is presented with out_valid for a single cycle. The
// pipeline is four front stages (operand capture, major axis pick, coordinate
// offset, size multiply), thirteen restoring divider stages that produce one
// quotient bit each, and the output register. A zero direction yields face 5,
// texel 0,0 and out_zero_direction high. Write the base size registers only when
// no transaction is in flight.
module cube_map_face_texel_address
  import cmfta_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_dir_x,
  input  logic signed [COORD_BITS-1:0] in_dir_y,
  input  logic signed [COORD_BITS-1:0] in_dir_z,
  input  logic [LVL_W-1:0]             in_mip_level,
  output logic                         out_valid,
  output logic [FACE_W-1:0]            out_face,
  output logic [IMG_W-1:0]             out_image_index,
  output logic [TEXEL_W-1:0]           out_texel_x,
  output logic [TEXEL_W-1:0]           out_texel_y,
  output logic                         out_zero_direction,
  input  logic                         cfg_wr_en,
  input  cfg_index_t                   cfg_index,
  input  logic [SIZE_W-1:0]            cfg_data
);

  localparam int CW     = COORD_BITS;
  localparam int SUM_W  = CW + 1;
  localparam int NUM_W  = SUM_W + SIZE_W;
  localparam int QUO_W  = SIZE_W;
  localparam int LATENCY = QUO_W + 5;

  // Configuration registers
  logic [SIZE_W-1:0] base_width_r, base_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_width_r  <= BASE_RESET;
      base_height_r <= BASE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BASE_WIDTH:  base_width_r  <= cfg_data;
        CFG_BASE_HEIGHT: base_height_r <= cfg_data;
        default:         base_width_r  <= base_width_r;
      endcase
    end
  end

  logic in_accept;
  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // ---------------- Stage 1: capture, magnitudes, level sizes ----------------
  logic                 vld_s1_r;
  logic signed [CW-1:0] dir_s1_r [3];
  logic [CW-1:0]        mag_s1_r [3];
  logic [LVL_W-1:0]     lvl_s1_r;
  logic [SIZE_W-1:0]    w_s1_r, h_s1_r;

  logic signed [CW-1:0] dir_in [3];
  logic [LVL_W-1:0]     lvl_sat;

  assign dir_in[0] = in_dir_x;
  assign dir_in[1] = in_dir_y;
  assign dir_in[2] = in_dir_z;
  assign lvl_sat   = (in_mip_level > MAX_LEVEL) ? MAX_LEVEL : in_mip_level;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dir_s1_r[i] <= dir_in[i];
      mag_s1_r[i] <= dir_in[i][CW-1] ? CW'(~dir_in[i] + 1'b1) : CW'(dir_in[i]);
    end
    lvl_s1_r <= lvl_sat;
    w_s1_r   <= level_size(base_width_r, lvl_sat);
    h_s1_r   <= level_size(base_height_r, lvl_sat);
  end

  // ---------------- Stage 2: major axis, face, image index ----------------
  logic                 vld_s2_r;
  logic [CW-1:0]        m_s2_r;
  logic signed [CW-1:0] cn_s2_r, ca_s2_r;
  side_t                side_s2_r;

  axis_t                axis;
  logic [CW-1:0]        m_sel;
  logic signed [CW-1:0] major, cn_sel, ca_sel;
  logic                 neg;
  logic [FACE_W-1:0]    face_sel;

  always_comb begin
    axis = AXIS_X;
    if (!(mag_s1_r[0] > mag_s1_r[1])) begin
      axis = AXIS_Y;
    end
    if (!(((axis == AXIS_Y) ? mag_s1_r[1] : mag_s1_r[0]) > mag_s1_r[2])) begin
      axis = AXIS_Z;
    end
  end

  // Route the major component and the two cyclically following ones
  always_comb begin
    unique case (axis)
      AXIS_X: begin
        major  = dir_s1_r[0];
        m_sel  = mag_s1_r[0];
        cn_sel = dir_s1_r[1];
        ca_sel = dir_s1_r[2];
      end
      AXIS_Y: begin
        major  = dir_s1_r[1];
        m_sel  = mag_s1_r[1];
        cn_sel = dir_s1_r[2];
        ca_sel = dir_s1_r[0];
      end
      default: begin
        major  = dir_s1_r[2];
        m_sel  = mag_s1_r[2];
        cn_sel = dir_s1_r[0];
        ca_sel = dir_s1_r[1];
      end
    endcase
  end

  assign neg      = major[CW-1] || (major == '0);
  assign face_sel = {axis, neg};

  always_ff @(posedge clk) begin
    m_s2_r                <= m_sel;
    cn_s2_r               <= cn_sel;
    ca_s2_r               <= ca_sel;
    side_s2_r.face        <= face_sel;
    side_s2_r.image_index <= IMG_W'(lvl_s1_r) * IMG_W'(6) + IMG_W'(face_sel);
    side_s2_r.zero        <= (m_sel == '0);
    side_s2_r.w           <= w_s1_r;
    side_s2_r.h           <= h_s1_r;
  end

  // ---------------- Stage 3: offset coordinates, divisor 2m ----------------
  logic              vld_s3_r;
  logic [SUM_W-1:0]  sx_s3_r, sy_s3_r, div_s3_r;
  side_t             side_s3_r;

  always_ff @(posedge clk) begin
    sx_s3_r   <= {cn_s2_r[CW-1], cn_s2_r} + {1'b0, m_s2_r};
    sy_s3_r   <= {ca_s2_r[CW-1], ca_s2_r} + {1'b0, m_s2_r};
    div_s3_r  <= {m_s2_r, 1'b0};
    side_s3_r <= side_s2_r;
  end

  // ---------------- Stage 4 and divider: one quotient bit per stage ----------------
  logic              vld_d_r  [0:QUO_W];
  logic [NUM_W-1:0]  rem_x_r  [0:QUO_W];
  logic [NUM_W-1:0]  rem_y_r  [0:QUO_W];
  logic [QUO_W-1:0]  quo_x_r  [0:QUO_W];
  logic [QUO_W-1:0]  quo_y_r  [0:QUO_W];
  logic [SUM_W-1:0]  div_d_r  [0:QUO_W];
  side_t             side_d_r [0:QUO_W];

  logic [NUM_W-1:0]  rem_x_nxt [1:QUO_W];
  logic [NUM_W-1:0]  rem_y_nxt [1:QUO_W];
  logic [QUO_W-1:0]  quo_x_nxt [1:QUO_W];
  logic [QUO_W-1:0]  quo_y_nxt [1:QUO_W];
  logic [NUM_W-1:0]  trial     [0:QUO_W-1];

  // Compare and subtract the shifted divisor, most significant quotient bit first
  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      trial[k]       = NUM_W'(div_d_r[k]) << (QUO_W - 1 - k);
      rem_x_nxt[k+1] = rem_x_r[k];
      rem_y_nxt[k+1] = rem_y_r[k];
      quo_x_nxt[k+1] = quo_x_r[k];
      quo_y_nxt[k+1] = quo_y_r[k];
      if (rem_x_r[k] >= trial[k]) begin
        rem_x_nxt[k+1]              = rem_x_r[k] - trial[k];
        quo_x_nxt[k+1][QUO_W-1-k]   = 1'b1;
      end
      if (rem_y_r[k] >= trial[k]) begin
        rem_y_nxt[k+1]              = rem_y_r[k] - trial[k];
        quo_y_nxt[k+1][QUO_W-1-k]   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_x_r[0]  <= NUM_W'(sx_s3_r) * NUM_W'(side_s3_r.w);
    rem_y_r[0]  <= NUM_W'(sy_s3_r) * NUM_W'(side_s3_r.h);
    quo_x_r[0]  <= '0;
    quo_y_r[0]  <= '0;
    div_d_r[0]  <= div_s3_r;
    side_d_r[0] <= side_s3_r;
    for (int k = 1; k <= QUO_W; k++) begin
      rem_x_r[k]  <= rem_x_nxt[k];
      rem_y_r[k]  <= rem_y_nxt[k];
      quo_x_r[k]  <= quo_x_nxt[k];
      quo_y_r[k]  <= quo_y_nxt[k];
      div_d_r[k]  <= div_d_r[k-1];
      side_d_r[k] <= side_d_r[k-1];
    end
  end

  // Advance valid bits through every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r <= 1'b0;
      vld_s2_r <= 1'b0;
      vld_s3_r <= 1'b0;
      for (int k = 0; k <= QUO_W; k++) begin
        vld_d_r[k] <= 1'b0;
      end
    end else begin
      vld_s1_r   <= in_accept;
      vld_s2_r   <= vld_s1_r;
      vld_s3_r   <= vld_s2_r;
      vld_d_r[0] <= vld_s3_r;
      for (int k = 1; k <= QUO_W; k++) begin
        vld_d_r[k] <= vld_d_r[k-1];
      end
    end
  end

  // ---------------- Output register: clamp, and zero the texel for a zero direction ----------------
  logic                out_valid_r;
  logic [FACE_W-1:0]   out_face_r;
  logic [IMG_W-1:0]    out_img_r;
  logic [TEXEL_W-1:0]  out_tx_r, out_ty_r;
  logic                out_zero_r;

  side_t               side_f;
  logic [SIZE_W-1:0]   w_m1, h_m1, tx_clamp, ty_clamp;

  assign side_f   = side_d_r[QUO_W];
  assign w_m1     = side_f.w - 1'b1;
  assign h_m1     = side_f.h - 1'b1;
  assign tx_clamp = (quo_x_r[QUO_W] > w_m1) ? w_m1 : quo_x_r[QUO_W];
  assign ty_clamp = (quo_y_r[QUO_W] > h_m1) ? h_m1 : quo_y_r[QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_d_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    out_face_r <= side_f.face;
    out_img_r  <= side_f.image_index;
    out_zero_r <= side_f.zero;
    out_tx_r   <= side_f.zero ? '0 : tx_clamp[TEXEL_W-1:0];
    out_ty_r   <= side_f.zero ? '0 : ty_clamp[TEXEL_W-1:0];
  end

  assign out_valid          = out_valid_r;
  assign out_face           = out_face_r;
  assign out_image_index    = out_img_r;
  assign out_texel_x        = out_tx_r;
  assign out_texel_y        = out_ty_r;
  assign out_zero_direction = out_zero_r;

`ifndef SYNTHESIS
  // Every accepted transaction yields its result strobe at the pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##LATENCY out_valid)
    else $error("result strobe missing at pipeline depth");

  // A zero direction maps to the negative z face at texel 0,0
  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_direction) |->
      (out_face == 3'd5 && out_texel_x == '0 && out_texel_y == '0))
    else $error("zero direction result malformed");

  // Face code stays within the six faces
  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_face <= 3'd5))
    else $error("face code out of range");

  // No result strobe without a transaction in the pipeline
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_d_r[QUO_W]))
    else $error("result strobe without a transaction");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the cube map face and texel address unit.

// Expected address store with its own copy of the face size registers
class texel_scoreboard;

  typedef struct {
    logic [cmfta_pkg::FACE_W-1:0]  face;
    logic [cmfta_pkg::IMG_W-1:0]   image_index;
    logic [cmfta_pkg::TEXEL_W-1:0] texel_x;
    logic [cmfta_pkg::TEXEL_W-1:0] texel_y;
    logic                          zero_direction;
  } texel_addr_t;

  logic [cmfta_pkg::SIZE_W-1:0] base_w;
  logic [cmfta_pkg::SIZE_W-1:0] base_h;
  texel_addr_t                  pending_addr[$];
  int                           failures;

  function new();
    base_w   = cmfta_pkg::BASE_RESET;
    base_h   = cmfta_pkg::BASE_RESET;
    failures = 0;
  endfunction

  function void write_reg(cmfta_pkg::cfg_index_t idx, logic [cmfta_pkg::SIZE_W-1:0] data);
    if (idx == cmfta_pkg::CFG_BASE_WIDTH) begin
      base_w = data;
    end else begin
      base_h = data;
    end
  endfunction

  function int pending();
    return pending_addr.size();
  endfunction

  // Face extent at a level: base held within 1..4096, halved per level, never below 1
  function longint face_extent(logic [cmfta_pkg::SIZE_W-1:0] base, int lvl);
    longint b;
    b = base;
    if (b < 1) b = 1;
    if (b > 4096) b = 4096;
    b = b >> lvl;
    return (b < 1) ? 1 : b;
  endfunction

  // Project one minor component onto the face and clamp to the last texel
  function longint project_minor(longint c, longint m, longint extent);
    longint t;
    t = ((c + m) * extent) / (2 * m);
    return (t > extent - 1) ? extent - 1 : t;
  endfunction

  function texel_addr_t predict_address(logic signed [15:0] dx, logic signed [15:0] dy,
                                        logic signed [15:0] dz, logic [3:0] mip);
    longint                d[3];
    longint                mag[3];
    cmfta_pkg::axis_t      major;
    int                    a;
    int                    lvl;
    int                    face_no;
    longint                m;
    texel_addr_t           r;
    d[0] = dx;
    d[1] = dy;
    d[2] = dz;
    for (int i = 0; i < 3; i++) mag[i] = (d[i] < 0) ? -d[i] : d[i];
    // Ties go to the later axis
    a = 0;
    for (int i = 1; i < 3; i++) if (mag[a] <= mag[i]) a = i;
    major = cmfta_pkg::axis_t'(a);
    lvl = (mip > cmfta_pkg::MAX_LEVEL) ? int'(cmfta_pkg::MAX_LEVEL) : int'(mip);
    face_no = int'(major) * 2 + ((d[a] > 0) ? 0 : 1);
    m = mag[a];
    r.face = face_no[cmfta_pkg::FACE_W-1:0];
    r.image_index = 7'(lvl * 6 + face_no);
    if (m == 0) begin
      r.zero_direction = 1'b1;
      r.texel_x = '0;
      r.texel_y = '0;
    end else begin
      r.zero_direction = 1'b0;
      r.texel_x = 12'(project_minor(d[(a + 1) % 3], m, face_extent(base_w, lvl)));
      r.texel_y = 12'(project_minor(d[(a + 2) % 3], m, face_extent(base_h, lvl)));
    end
    return r;
  endfunction

  function void note_lookup(logic signed [15:0] dx, logic signed [15:0] dy,
                            logic signed [15:0] dz, logic [3:0] mip);
    pending_addr.push_back(predict_address(dx, dy, dz, mip));
  endfunction

  function void compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      failures++;
    end
  endfunction

  function void check_result(texel_addr_t act);
    texel_addr_t exp_a;
    if (pending_addr.size() == 0) begin
      $display("%0t: result with nothing outstanding, face %0d texel %0d,%0d",
               $time, act.face, act.texel_x, act.texel_y);
      failures++;
      return;
    end
    exp_a = pending_addr.pop_front();
    compare_field("face", exp_a.face, act.face);
    compare_field("image_index", exp_a.image_index, act.image_index);
    compare_field("texel_x", exp_a.texel_x, act.texel_x);
    compare_field("texel_y", exp_a.texel_y, act.texel_y);
    compare_field("zero_direction", exp_a.zero_direction, act.zero_direction);
  endfunction

endclass

module testbench;
  import cmfta_pkg::*;

  localparam int COORD_BITS    = 16;
  localparam int PIPE_LATENCY  = 18;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 205;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic signed [COORD_BITS-1:0] in_dir_x;
  logic signed [COORD_BITS-1:0] in_dir_y;
  logic signed [COORD_BITS-1:0] in_dir_z;
  logic [LVL_W-1:0]             in_mip_level;
  logic                         out_valid;
  logic [FACE_W-1:0]            out_face;
  logic [IMG_W-1:0]             out_image_index;
  logic [TEXEL_W-1:0]           out_texel_x;
  logic [TEXEL_W-1:0]           out_texel_y;
  logic                         out_zero_direction;
  logic                         cfg_wr_en;
  cfg_index_t                   cfg_index;
  logic [SIZE_W-1:0]            cfg_data;

  texel_scoreboard sb;
  int              idle_pct;
  int              quiet_cycles;

  cube_map_face_texel_address #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_dir_x           (in_dir_x),
    .in_dir_y           (in_dir_y),
    .in_dir_z           (in_dir_z),
    .in_mip_level       (in_mip_level),
    .out_valid          (out_valid),
    .out_face           (out_face),
    .out_image_index    (out_image_index),
    .out_texel_x        (out_texel_x),
    .out_texel_y        (out_texel_y),
    .out_zero_direction (out_zero_direction),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Note accepted lookups, register writes and results at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) begin
        sb.write_reg(cfg_index, cfg_data);
      end
      if (start && !busy) begin
        sb.note_lookup(in_dir_x, in_dir_y, in_dir_z, in_mip_level);
      end
      if (out_valid) begin
        sb.check_result('{out_face, out_image_index, out_texel_x, out_texel_y,
                          out_zero_direction});
      end
    end
  end

  // Abort when nothing has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one lookup from a falling edge and hold it until the unit takes it
  task automatic drive_lookup(input logic signed [15:0] dx, input logic signed [15:0] dy,
                              input logic signed [15:0] dz, input logic [3:0] mip);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_dir_x     = dx;
    in_dir_y     = dy;
    in_dir_z     = dz;
    in_mip_level = mip;
    start        = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Stop sending and wait until every outstanding address has come back
  task automatic drain_lookups(input bit with_pause);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    if (with_pause) begin
      repeat (PIPE_LATENCY + 2) @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic write_face_size(input cfg_index_t idx, input logic [SIZE_W-1:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic signed [15:0] random_component(input int mode);
    logic signed [15:0] edges[5];
    edges = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};
    case (mode)
      0: return 16'($urandom());
      1: return 16'(int'($urandom_range(8)) - 4);
      2: return edges[$urandom_range(4)];
      default: return 16'($signed($urandom()) >>> $urandom_range(16, 30));
    endcase
  endfunction

  // Random lookup: mixed component scales, with forced magnitude ties now and then
  task automatic random_lookup();
    logic signed [15:0] c[3];
    int                 src;
    int                 dst;
    for (int i = 0; i < 3; i++) c[i] = random_component($urandom_range(5));
    if ($urandom_range(5) == 0) begin
      src = $urandom_range(2);
      dst = (src + 1 + $urandom_range(1)) % 3;
      c[dst] = $urandom_range(1) ? c[src] : -c[src];
    end
    drive_lookup(c[0], c[1], c[2], 4'($urandom_range(15)));
  endtask

  initial begin
    logic [SIZE_W-1:0] w_set;
    logic [SIZE_W-1:0] h_set;
    sb           = new();
    rst_n        = 1'b0;
    start        = 1'b0;
    in_dir_x     = '0;
    in_dir_y     = '0;
    in_dir_z     = '0;
    in_mip_level = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_BASE_WIDTH;
    cfg_data     = '0;
    idle_pct     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed lookups at the reset face size: faces, ties, zero and level extremes
    drive_lookup(16'sd0, 16'sd0, 16'sd0, 4'd0);
    drive_lookup(16'sd0, 16'sd0, 16'sd0, 4'd15);
    drive_lookup(16'sd32767, 16'sd0, 16'sd0, 4'd0);
    drive_lookup(-16'sd32768, 16'sd0, 16'sd0, 4'd0);
    drive_lookup(16'sd0, 16'sd32767, 16'sd0, 4'd0);
    drive_lookup(16'sd0, -16'sd32768, 16'sd0, 4'd3);
    drive_lookup(16'sd0, 16'sd0, 16'sd32767, 4'd5);
    drive_lookup(16'sd0, 16'sd0, -16'sd32768, 4'd12);
    drive_lookup(-16'sd32768, 16'sd32767, 16'sd32767, 4'd0);
    drive_lookup(-16'sd32768, -16'sd32768, -16'sd32768, 4'd0);
    drive_lookup(16'sd100, 16'sd100, 16'sd0, 4'd0);
    drive_lookup(16'sd0, -16'sd7, 16'sd7, 4'd1);
    drive_lookup(-16'sd5, 16'sd5, 16'sd0, 4'd2);
    drive_lookup(16'sd5, -16'sd5, 16'sd0, 4'd2);
    drive_lookup(16'sd32767, 16'sd32767, -16'sd32768, 4'd0);
    drive_lookup(16'sd1, -16'sd1, 16'sd1, 4'd0);
    drive_lookup(16'sd32767, -16'sd32767, 16'sd32767, 4'd13);
    drive_lookup(16'sd1000, 16'sd999, -16'sd1000, 4'd4);
    drive_lookup(-16'sd1, 16'sd0, 16'sd0, 4'd0);
    drive_lookup(16'sd3, 16'sd3, -16'sd3, 4'd14);
    drive_lookup(16'sd0, 16'sd0, 16'sd1, 4'd9);
    drive_lookup(16'sd12, -16'sd12, 16'sd5, 4'd11);
    drive_lookup(-16'sd32767, 16'sd32767, -16'sd1, 4'd8);

    // Random phases, each with its own face size, cycling through three sender idling levels
    for (int p = 0; p < PHASES; p++) begin
      drain_lookups(1'b1);
      case (p)
        0: begin w_set = 13'd4096; h_set = 13'd4096; end
        1: begin w_set = 13'd1;    h_set = 13'd1;    end
        2: begin w_set = 13'd0;    h_set = 13'd8191; end
        3: begin w_set = 13'd8191; h_set = 13'd0;    end
        4: begin
          w_set = 13'($urandom_range(1, 4096));
          h_set = 13'($urandom_range(1, 4096));
        end
        default: begin
          w_set = 13'($urandom());
          h_set = 13'($urandom_range(1, 4096));
        end
      endcase
      write_face_size(CFG_BASE_WIDTH, w_set);
      write_face_size(CFG_BASE_HEIGHT, h_set);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 46;
        default: idle_pct = 11;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // In phase 1, hold the sender mid-phase until the pipeline has emptied
        if (p == 1 && n == PHASE_ITEMS / 2) begin
          drain_lookups(1'b0);
        end
        random_lookup();
      end
    end

    drain_lookups(1'b1);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cmfta_pkg.sv
rtl/cube_map_face_texel_address.sv
tb/sv/testbench.sv
